@@ design/phasor_sine_pwm_with_power_triangle_defines.svh @@
// Assertion macros shared by the checker.
`ifndef PHASOR_SINE_PWM_WITH_POWER_TRIANGLE_DEFINES_SVH
`define PHASOR_SINE_PWM_WITH_POWER_TRIANGLE_DEFINES_SVH
// implication checked every clock, quiet during reset
`define PSP_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication
`define PSP_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

@@ design/psp_pkg.sv @@
// ----------------------------------------------------------------------------
// psp_pkg
// Types and constants of the sine PWM / power triangle block.
// ----------------------------------------------------------------------------
package psp_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [17:0] SINE_X0 = 18'sd19898;
  localparam logic [10:0] CUR_AMP_RST = 11'd620;
  localparam logic [19:0] MICRO = 20'd1000000;

  localparam logic [1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [1:0] REG_FREQ       = 2'd1;
  localparam logic [1:0] REG_PWM_IVL    = 2'd2;
  localparam logic [1:0] REG_RPT_IVL    = 2'd3;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0: v = 32'd536870912;  4'd1: v = 32'd316933406;
      4'd2: v = 32'd167458907;  4'd3: v = 32'd85004756;
      4'd4: v = 32'd42667331;   4'd5: v = 32'd21354465;
      4'd6: v = 32'd10679838;   4'd7: v = 32'd5340245;
      4'd8: v = 32'd2670163;    4'd9: v = 32'd1335087;
      4'd10: v = 32'd667544;    4'd11: v = 32'd333772;
      4'd12: v = 32'd166886;    4'd13: v = 32'd83443;
      4'd14: v = 32'd41722;     4'd15: v = 32'd20861;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // controller steps
  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_TPH, ST_DIV, ST_SINV, ST_SINC, ST_SQRT, ST_ATAN,
    ST_AMP, ST_DONE
  } psp_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // latch input word
    logic prep;     // scaled knobs, products
    logic div_go;   // one step of shared divider
    logic div_amp;  // divider runs S / a
    logic sinv_init;
    logic sinc_init;
    logic cordic;   // one CORDIC step
    logic sqrt_step;
    logic atan_init;
    logic commit;   // update state, build result
    logic [1:0] div_sel;
  } psp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic do_pwm;
    logic do_rpt;
    logic div_done;
    logic cordic_done;
    logic sqrt_done;
  } psp_sts_t;

  typedef struct packed {
    logic        pwm_update;
    logic [11:0] duty_voltage;
    logic [11:0] duty_current;
    logic        report_valid;
    logic [21:0] real_power;
    logic [21:0] reactive_power;
    logic [22:0] apparent_power;
    logic [14:0] power_angle;
    logic [15:0] current_phase_out;
    logic [10:0] current_amplitude_out;
    logic [10:0] voltage_amplitude;
  } psp_res_t;

  typedef struct packed {
    logic [31:0] time_us;
    logic [11:0] knob_amplitude;
    logic [11:0] knob_phase;
    logic [11:0] knob_real;
    logic [11:0] knob_reactive;
  } psp_in_t;
endpackage

@@ design/psp_if.sv @@
// ----------------------------------------------------------------------------
// psp_in_if / psp_out_if / psp_cfg_if
// Valid/ready channels of the block.
// ----------------------------------------------------------------------------
interface psp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_us;
  logic [11:0] knob_amplitude;
  logic [11:0] knob_phase;
  logic [11:0] knob_real;
  logic [11:0] knob_reactive;
  modport source (output valid, time_us, knob_amplitude, knob_phase, knob_real,
                  knob_reactive, input ready);
  modport sink (input valid, time_us, knob_amplitude, knob_phase, knob_real,
                knob_reactive, output ready);
endinterface

interface psp_out_if;
  logic        valid;
  logic        ready;
  logic        pwm_update;
  logic [11:0] duty_voltage;
  logic [11:0] duty_current;
  logic        report_valid;
  logic [21:0] real_power;
  logic [21:0] reactive_power;
  logic [22:0] apparent_power;
  logic [14:0] power_angle;
  logic [15:0] current_phase_out;
  logic [10:0] current_amplitude_out;
  logic [10:0] voltage_amplitude;
  modport source (output valid, pwm_update, duty_voltage, duty_current, report_valid,
                  real_power, reactive_power, apparent_power, power_angle,
                  current_phase_out, current_amplitude_out, voltage_amplitude,
                  input ready);
  modport sink (input valid, pwm_update, duty_voltage, duty_current, report_valid,
                real_power, reactive_power, apparent_power, power_angle,
                current_phase_out, current_amplitude_out, voltage_amplitude,
                output ready);
endinterface

interface psp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/psp_ctrl.sv @@
// ----------------------------------------------------------------------------
// psp_ctrl
// Sequencer: steps the shared divider, CORDIC and root units.
// ----------------------------------------------------------------------------
module psp_ctrl import psp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  psp_sts_t sts,
  output psp_cmd_t cmd,
  output logic     busy,
  output logic     res_valid
);
  psp_state_t state_r, state_nxt;
  logic [1:0] dsel_r, dsel_nxt;
  logic       out_full_r, out_full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dsel_r     <= 2'd0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dsel_r     <= dsel_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  assign res_valid = out_full_r;

  always_comb begin
    state_nxt = state_r;
    dsel_nxt  = dsel_r;
    cmd       = '0;
    cmd.div_sel = dsel_r;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // div 0: amplitude scale, div 1: phase scale
        cmd.prep = 1'b1;
        dsel_nxt = 2'd0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_go = 1'b1;
        if (sts.div_done) begin
          case (dsel_r)
            2'd0: dsel_nxt = 2'd1;
            2'd1: begin
              if (sts.do_pwm) begin
                dsel_nxt = 2'd2;
              end else begin
                state_nxt = ST_SQRT;
              end
            end
            2'd2: dsel_nxt = 2'd3;
            default: state_nxt = ST_TPH;
          endcase
        end
      end
      ST_TPH: begin
        // time angle now registered, start voltage sine
        cmd.sinv_init = 1'b1;
        state_nxt = ST_SINV;
      end
      ST_SINV: begin
        cmd.cordic = 1'b1;
        if (sts.cordic_done) begin
          cmd.sinc_init = 1'b1;
          state_nxt = ST_SINC;
        end
      end
      ST_SINC: begin
        cmd.cordic = 1'b1;
        if (sts.cordic_done) state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (!sts.do_rpt) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.sqrt_step = 1'b1;
          if (sts.sqrt_done) begin
            cmd.atan_init = 1'b1;
            state_nxt = ST_ATAN;
          end
        end
      end
      ST_ATAN: begin
        cmd.cordic = 1'b1;
        if (sts.cordic_done) state_nxt = ST_AMP;
      end
      ST_AMP: begin
        cmd.div_go = 1'b1;
        cmd.div_amp = 1'b1;
        cmd.div_sel = 2'd3;
        if (sts.div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // commit only once the output register is free
        if (!out_full_r || out_fire) begin
          cmd.commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_full_nxt = out_full_r;
    if (out_fire) out_full_nxt = 1'b0;
    if (cmd.commit) out_full_nxt = 1'b1;
  end
endmodule

@@ design/psp_dp.sv @@
// ----------------------------------------------------------------------------
// psp_dp
// Datapath: registers, shared restoring divider, CORDIC, square root.
// ----------------------------------------------------------------------------
module psp_dp import psp_pkg::*; #(
  parameter int ADC_FULL_SCALE = 4095,
  parameter int PHASE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  psp_in_t     in_word,
  input  psp_cmd_t    cmd,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output psp_sts_t    sts,
  output psp_res_t    res
);
  localparam int PB = PHASE_BITS;
  localparam logic [15:0] ADC_FS = 16'(ADC_FULL_SCALE);

  logic [10:0] fs_r;
  logic [9:0]  freq_r;
  logic [19:0] pwm_ivl_r;
  logic [23:0] rpt_ivl_r;
  logic [31:0] last_pwm_r, last_rpt_r;
  logic [10:0] cur_amp_r;
  logic [PB-1:0] cur_ph_r;

  psp_in_t     in_r;
  logic        do_pwm_r, do_rpt_r;
  logic [21:0] p_r, q_r;
  logic [10:0] amp_r;
  logic [PB-1:0] vph_r, tph_r;
  logic [11:0] dv_r, dc_r;
  logic [22:0] s_r;
  logic [PB-1:0] th_r;
  logic [10:0] a2_r;
  psp_res_t    res_r;

  // shared divider: 48-bit dividend, 32-bit divisor, 2 quotient bits/cycle
  logic [47:0] dq_r;      // dividend shifting into quotient
  logic [32:0] drem_r;
  logic [31:0] dden_r;
  logic [4:0]  dcnt_r;
  logic        dact_r;

  // CORDIC
  logic signed [49:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic [4:0]  ccnt_r;
  logic [1:0]  cmode_r;  // 0 sine, 1 vector
  logic        cneg_r, cstop_r;

  // root
  logic [45:0] sv_r, sr_r;
  logic [4:0]  scnt_r;

  logic [11:0] k1s, k2s;
  assign k1s = (16'(in_r.knob_amplitude) > ADC_FS) ? ADC_FS[11:0] : in_r.knob_amplitude;
  assign k2s = (16'(in_r.knob_phase) > ADC_FS) ? ADC_FS[11:0] : in_r.knob_phase;

  assign sts.do_pwm = do_pwm_r;
  assign sts.do_rpt = do_rpt_r;
  assign sts.div_done = dact_r && (dcnt_r == 5'd0);
  assign sts.cordic_done = (ccnt_r == 5'(CORDIC_STEPS)) || cstop_r;
  assign sts.sqrt_done = (scnt_r == 5'd23);
  assign res = res_r;

  // divider start values for each use
  logic [47:0] dn;
  logic [31:0] dd;
  logic [43:0] ftprod;
  assign ftprod = 44'(freq_r) * 44'(in_r.time_us);
  always_comb begin
    case (cmd.div_sel)
      2'd0: begin dn = 48'(23'(k1s) * 23'(fs_r)); dd = 32'(ADC_FS); end
      2'd1: begin dn = 48'(k2s) << PB; dd = 32'(ADC_FS); end
      2'd2: begin dn = 48'(ftprod); dd = 32'(MICRO); end
      default: begin
        if (cmd.div_amp) begin
          dn = 48'(s_r); dd = 32'(amp_r);
        end else begin
          dn = 48'(drem_r[31:0]) << PB; dd = 32'(MICRO);
        end
      end
    endcase
  end

  logic [32:0] r1, r2;
  logic        b1, b2;
  always_comb begin
    r1 = {drem_r[31:0], dq_r[47]};
    b1 = r1 >= 33'(dden_r);
    if (b1) r1 = r1 - 33'(dden_r);
    r2 = {r1[31:0], dq_r[46]};
    b2 = r2 >= 33'(dden_r);
    if (b2) r2 = r2 - 33'(dden_r);
  end

  // sine CORDIC start
  function automatic logic signed [33:0] red_ang(input logic [PB-1:0] ph,
                                                  output logic neg);
    logic signed [33:0] z;
    z = $signed({2'b00, 32'(ph) << (32 - PB)});
    neg = 1'b0;
    if (z >= 34'sd2147483648) z = z - 34'sd4294967296;
    if (z > 34'sd1073741824) begin
      z = z - 34'sd2147483648; neg = 1'b1;
    end else if (z < -34'sd1073741824) begin
      z = z + 34'sd2147483648; neg = 1'b1;
    end
    return z;
  endfunction

  logic [PB-1:0] angv, angc;
  logic signed [33:0] zv, zc;
  logic nv, nc;
  assign angv = tph_r + vph_r;
  assign angc = tph_r + cur_ph_r;
  always_comb begin
    zv = red_ang(angv, nv);
    zc = red_ang(angc, nc);
  end

  // CORDIC step
  logic signed [49:0] sx, sy, nxx, nyy;
  logic signed [33:0] at, nzz;
  logic dirp;
  always_comb begin
    sx = cx_r >>> ccnt_r[3:0];
    sy = cy_r >>> ccnt_r[3:0];
    at = $signed({2'b00, atan_turn(ccnt_r[3:0])});
    dirp = (cmode_r == 2'd0) ? (cz_r >= 0) : (cy_r < 0);
    if (dirp) begin
      nxx = cx_r - sy; nyy = cy_r + sx;
      nzz = cz_r - at;
    end else begin
      nxx = cx_r + sy; nyy = cy_r - sx;
      nzz = cz_r + at;
    end
  end

  // duty from sine result
  function automatic logic [11:0] mk_duty(input logic [10:0] a,
                                          input logic signed [49:0] y, input logic n);
    logic signed [49:0] yy;
    logic signed [16:0] ys;
    logic signed [28:0] pr;
    logic signed [29:0] d;
    yy = n ? -y : y;
    if (yy > 50'sd32767) yy = 50'sd32767;
    if (yy < -50'sd32768) yy = -50'sd32768;
    ys = 17'(yy);
    pr = $signed({1'b0, a}) * ys;
    d = 30'(pr >>> 15) + 30'sd2048;
    if (d < 0) d = 0;
    if (d > 30'sd4095) d = 30'sd4095;
    return d[11:0];
  endfunction

  // root step
  logic [45:0] sbit, snv, snr;
  always_comb begin
    sbit = 46'd1 << (6'd44 - {scnt_r, 1'b0});
    if (sv_r >= sr_r + sbit) begin
      snv = sv_r - (sr_r + sbit); snr = (sr_r >> 1) + sbit;
    end else begin
      snv = sv_r; snr = sr_r >> 1;
    end
  end

  // full scale / 7 by reciprocal multiply, exact below 5461
  logic [10:0] lim;
  assign lim = 11'((23'(fs_r) * 23'd2341) >> 14);

  // arctangent output rounding
  logic signed [33:0] zcl;
  logic [33:0] zr;
  always_comb begin
    zcl = cz_r;
    if (zcl < 0) zcl = 0;
    if (zcl > 34'sd1073741824) zcl = 34'sd1073741824;
    zr = (34'(zcl) + (34'd1 << (31 - PB))) >> (32 - PB);
  end

  logic [31:0] dtp, dtr;
  assign dtp = in_word.time_us - last_pwm_r;
  assign dtr = in_word.time_us - last_rpt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= 11'd2000; freq_r <= 10'd60; pwm_ivl_r <= 20'd500; rpt_ivl_r <= 24'd500000;
      last_pwm_r <= '0; last_rpt_r <= '0; cur_amp_r <= CUR_AMP_RST; cur_ph_r <= '0;
      dact_r <= 1'b0; dcnt_r <= '0; ccnt_r <= '0; cstop_r <= 1'b0; scnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_FULL_SCALE: fs_r <= cfg_data[10:0];
          REG_FREQ:       freq_r <= cfg_data[9:0];
          REG_PWM_IVL:    pwm_ivl_r <= cfg_data[19:0];
          REG_RPT_IVL:    rpt_ivl_r <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        in_r <= in_word;
        do_pwm_r <= dtp > 32'(pwm_ivl_r);
        do_rpt_r <= dtr > 32'(rpt_ivl_r);
        dv_r <= '0; dc_r <= '0;
      end
      if (cmd.prep) begin
        p_r <= 22'((24'(in_r.knob_real) * 24'(in_r.knob_real)) >> 2);
        q_r <= 22'((24'(in_r.knob_reactive) * 24'(in_r.knob_reactive)) >> 2);
        sr_r <= '0; scnt_r <= '0;
      end
      if (cmd.div_go) begin
        if (!dact_r) begin
          dact_r <= 1'b1; dcnt_r <= 5'd24;
          dq_r <= dn; dden_r <= dd; drem_r <= '0;
        end else if (dcnt_r != 5'd0) begin
          dq_r <= {dq_r[45:0], b1, b2};
          drem_r <= r2;
          dcnt_r <= dcnt_r - 5'd1;
        end else begin
          dact_r <= 1'b0;
          case (cmd.div_sel)
            2'd0: amp_r <= 11'(dq_r);
            2'd1: vph_r <= PB'(dq_r);
            2'd2: drem_r <= drem_r; // remainder kept for second division
            default: begin
              if (cmd.div_amp)
                a2_r <= (amp_r == 0) ? lim :
                        ((dq_r > 48'(lim)) ? lim : 11'(dq_r));
              else
                tph_r <= PB'(dq_r);
            end
          endcase
        end
      end
      if (cmd.div_go && dact_r && dcnt_r == 5'd0 && cmd.div_sel == 2'd1) begin
        sv_r <= 46'(p_r) * 46'(p_r) + 46'(q_r) * 46'(q_r);
        sr_r <= '0; scnt_r <= '0;
      end
      if (cmd.sinv_init || cmd.sinc_init) begin
        cx_r <= 50'(SINE_X0); cy_r <= '0; ccnt_r <= '0; cmode_r <= 2'd0; cstop_r <= 1'b0;
        cz_r <= cmd.sinv_init ? zv : zc;
        cneg_r <= cmd.sinv_init ? nv : nc;
      end else if (cmd.atan_init) begin
        cx_r <= $signed({12'd0, p_r, 16'd0}); cy_r <= $signed({12'd0, q_r, 16'd0});
        cz_r <= '0; ccnt_r <= '0; cmode_r <= 2'd1; cstop_r <= (q_r == 0);
      end else if (cmd.cordic) begin
        if (!sts.cordic_done) begin
          cx_r <= nxx; cy_r <= nyy; cz_r <= nzz; ccnt_r <= ccnt_r + 5'd1;
          if (cmode_r == 2'd1 && nyy == 0) cstop_r <= 1'b1;
        end
      end
      if (cmd.cordic && sts.cordic_done && cmode_r == 2'd0) begin
        if (cmd.sinc_init) dv_r <= mk_duty(amp_r, cy_r, cneg_r);
        else dc_r <= mk_duty(cur_amp_r, cy_r, cneg_r);
      end
      if (cmd.atan_init) th_r <= PB'(zr);
      if (cmd.cordic && sts.cordic_done && cmode_r == 2'd1) th_r <= PB'(zr);
      if (cmd.sqrt_step && !sts.sqrt_done) begin
        sv_r <= snv; sr_r <= snr; scnt_r <= scnt_r + 5'd1;
      end
      if (cmd.sqrt_step && sts.sqrt_done) s_r <= 23'(sr_r);
      if (cmd.commit) begin
        res_r.pwm_update <= do_pwm_r;
        res_r.duty_voltage <= dv_r;
        res_r.duty_current <= dc_r;
        res_r.report_valid <= do_rpt_r;
        res_r.real_power <= do_rpt_r ? p_r : '0;
        res_r.reactive_power <= do_rpt_r ? q_r : '0;
        res_r.apparent_power <= do_rpt_r ? s_r : '0;
        res_r.power_angle <= do_rpt_r ? 15'(th_r) : '0;
        res_r.current_phase_out <= do_rpt_r ? 16'(PB'(vph_r - th_r)) : '0;
        res_r.current_amplitude_out <= do_rpt_r ? a2_r : '0;
        res_r.voltage_amplitude <= amp_r;
        if (do_pwm_r) last_pwm_r <= in_r.time_us;
        if (do_rpt_r) begin
          last_rpt_r <= in_r.time_us;
          cur_ph_r <= PB'(vph_r - th_r);
          cur_amp_r <= a2_r;
        end
      end
    end
  end
endmodule

@@ design/phasor_sine_pwm_with_power_triangle.sv @@
// ----------------------------------------------------------------------------
// phasor_sine_pwm_with_power_triangle
// Two-channel sine duty generator with power triangle report.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one word per control-loop sample (time, four knob readings).
//   out : one result word per input word (duty pair and/or report, or neither).
//   cfg : register writes (index 0..3), always ready; write only while idle.
// Sequence: each pass of the shared divider loads, runs 24 two-bit steps
//   and unloads. Every word runs the two knob divisions; a duty update
//   adds two time angle divisions, the setup state ST_TPH and two sine
//   CORDIC passes; a report adds the 23-step root, the vectoring CORDIC
//   pass, which can end early, and the amplitude division.
// Flow: one word at a time; the next word can be taken from the cycle
//   after the previous result is committed.
// Reset: synchronous, active low; registers take their defaults, the
//   current channel starts at amplitude 620 and phase 0.
// Stall: the result word is held in the output register until taken; the
//   next word is accepted and computed meanwhile, and waits before its
//   commit while the output register is still full.
// ----------------------------------------------------------------------------
module phasor_sine_pwm_with_power_triangle import psp_pkg::*; #(
  parameter int ADC_FULL_SCALE = 4095,
  parameter int PHASE_BITS     = 16
) (
  input  logic clk,
  input  logic rst_n,
  psp_in_if.sink    in_ch,
  psp_out_if.source out_ch,
  psp_cfg_if.sink   cfg_ch
);
  psp_cmd_t cmd;
  psp_sts_t sts;
  psp_res_t res;
  psp_in_t  in_word;
  logic busy, res_valid, in_fire, out_fire;

  assign in_ch.ready = !busy;
  assign in_fire  = in_ch.valid && !busy;
  assign out_fire = res_valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign in_word.time_us        = in_ch.time_us;
  assign in_word.knob_amplitude = in_ch.knob_amplitude;
  assign in_word.knob_phase     = in_ch.knob_phase;
  assign in_word.knob_real      = in_ch.knob_real;
  assign in_word.knob_reactive  = in_ch.knob_reactive;

  psp_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd, .busy, .res_valid
  );

  psp_dp #(.ADC_FULL_SCALE(ADC_FULL_SCALE), .PHASE_BITS(PHASE_BITS)) u_dp (
    .clk, .rst_n, .in_word, .cmd,
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data),
    .sts, .res
  );

  // result word
  assign out_ch.valid                 = res_valid;
  assign out_ch.pwm_update            = res.pwm_update;
  assign out_ch.duty_voltage          = res.duty_voltage;
  assign out_ch.duty_current          = res.duty_current;
  assign out_ch.report_valid          = res.report_valid;
  assign out_ch.real_power            = res.real_power;
  assign out_ch.reactive_power        = res.reactive_power;
  assign out_ch.apparent_power        = res.apparent_power;
  assign out_ch.power_angle           = res.power_angle;
  assign out_ch.current_phase_out     = res.current_phase_out;
  assign out_ch.current_amplitude_out = res.current_amplitude_out;
  assign out_ch.voltage_amplitude     = res.voltage_amplitude;
endmodule

@@ design/psp_checker.sv @@
// ----------------------------------------------------------------------------
// psp_checker
// Port-level checks of the block, bound to the top level.
// ----------------------------------------------------------------------------
`include "phasor_sine_pwm_with_power_triangle_defines.svh"
module psp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pwm_update,
  input logic report_valid,
  input logic [11:0] duty_voltage,
  input logic [22:0] apparent_power
);
  `PSP_ASSERT_NXT(a_rpt_hold, clk, rst_n, out_valid && !out_ready, $stable(apparent_power), "result changed while stalled")
  `PSP_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "still ready after accept")
  `PSP_ASSERT_IMP(a_duty_zero, clk, rst_n, out_valid && !pwm_update, duty_voltage == 12'd0, "duty without update")
  `PSP_ASSERT_IMP(a_rpt_zero, clk, rst_n, out_valid && !report_valid, apparent_power == 23'd0, "report data without report")
  `PSP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind phasor_sine_pwm_with_power_triangle psp_checker u_psp_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .pwm_update(out_ch.pwm_update), .report_valid(out_ch.report_valid),
  .duty_voltage(out_ch.duty_voltage), .apparent_power(out_ch.apparent_power)
);

@@ tb/phasor_sine_pwm_with_power_triangle_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phasor_sine_pwm_with_power_triangle_chk
// Watches the input, result and register channels of the sine duty / power
// triangle block. It predicts each result word and compares it with the
// observed one.
// ----------------------------------------------------------------------------
module phasor_sine_pwm_with_power_triangle_chk import psp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  psp_in_if    in_ch,
  psp_out_if   out_ch,
  psp_cfg_if   cfg_ch,
  output int   mismatches,
  output int   words_pending
);
  localparam longint KNOB_MAX = 4095;

  // arctangent of 2^-i in 2^-32 turns
  localparam longint ATAN_LUT [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic [10:0] full_scale;
  logic [9:0]  freq_hz;
  logic [19:0] pwm_ivl;
  logic [23:0] rpt_ivl;
  logic [31:0] pwm_stamp;
  logic [31:0] rpt_stamp;
  logic [10:0] cur_amp;
  logic [15:0] cur_phase;

  psp_res_t expected_words[$];

  function automatic longint cordic_sine(input logic [31:0] ang);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang);
    x = 19898;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_LUT[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_LUT[i];
      end
      x = nx;
    end
    if (flip) y = -y;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y;
  endfunction

  function automatic longint cordic_atan(input longint p, input longint q);
    longint x, y, z, nx;
    x = p << 16;
    y = q << 16;
    z = 0;
    for (int i = 0; i < 16 && y != 0; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_LUT[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_LUT[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > 64'sd1073741824) z = 64'sd1073741824;
    return (z + 32768) >> 16;
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [11:0] duty_count(input longint amp, input longint ph);
    longint d;
    d = ((amp * cordic_sine({ph[15:0], 16'h0000})) >>> 15) + 2048;
    if (d < 0) d = 0;
    if (d > 4095) d = 4095;
    return d[11:0];
  endfunction

  // predicts one result word and advances the predictor state
  function automatic psp_res_t predict_word(input psp_in_t w);
    psp_res_t r;
    longint k1, k2, k3, k4, amp, vph, p, q, tph, s, th, lim, a2;
    logic [31:0] t;
    t  = w.time_us;
    k1 = w.knob_amplitude;
    k2 = w.knob_phase;
    k3 = w.knob_real;
    k4 = w.knob_reactive;
    if (k1 > KNOB_MAX) k1 = KNOB_MAX;
    if (k2 > KNOB_MAX) k2 = KNOB_MAX;
    amp = k1 * full_scale / KNOB_MAX;
    vph = ((k2 << 16) / KNOB_MAX) & 16'hFFFF;
    p   = (k3 * k3) >> 2;
    q   = (k4 * k4) >> 2;
    r   = '0;
    r.voltage_amplitude = amp[10:0];
    if (32'(t - pwm_stamp) > 32'(pwm_ivl)) begin
      pwm_stamp = t;
      tph = (((longint'(freq_hz) * longint'(t)) % 1000000) << 16) / 1000000;
      r.pwm_update   = 1'b1;
      r.duty_voltage = duty_count(amp, tph + vph);
      r.duty_current = duty_count(cur_amp, tph + cur_phase);
    end
    if (32'(t - rpt_stamp) > 32'(rpt_ivl)) begin
      s   = int_sqrt(p * p + q * q);
      th  = cordic_atan(p, q);
      lim = full_scale / 7;
      a2  = (amp == 0) ? lim : s / amp;
      if (a2 > lim) a2 = lim;
      rpt_stamp = t;
      cur_phase = 16'(vph - th);
      cur_amp   = a2[10:0];
      r.report_valid          = 1'b1;
      r.real_power            = p[21:0];
      r.reactive_power        = q[21:0];
      r.apparent_power        = s[22:0];
      r.power_angle           = th[14:0];
      r.current_phase_out     = cur_phase;
      r.current_amplitude_out = cur_amp;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    psp_in_t  w;
    psp_res_t got, want;
    if (!rst_n) begin
      full_scale = 11'd2000;
      freq_hz    = 10'd60;
      pwm_ivl    = 20'd500;
      rpt_ivl    = 24'd500000;
      pwm_stamp  = '0;
      rpt_stamp  = '0;
      cur_amp    = 11'd620;
      cur_phase  = '0;
      expected_words.delete();
      mismatches = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_FULL_SCALE: full_scale = cfg_ch.data[10:0];
          REG_FREQ:       freq_hz    = cfg_ch.data[9:0];
          REG_PWM_IVL:    pwm_ivl    = cfg_ch.data[19:0];
          REG_RPT_IVL:    rpt_ivl    = cfg_ch.data[23:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pwm_update, out_ch.duty_voltage, out_ch.duty_current,
                out_ch.report_valid, out_ch.real_power, out_ch.reactive_power,
                out_ch.apparent_power, out_ch.power_angle, out_ch.current_phase_out,
                out_ch.current_amplitude_out, out_ch.voltage_amplitude};
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, pwm_update", got.pwm_update, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.pwm_update !== want.pwm_update)
            report_mismatch("pwm_update", got.pwm_update, want.pwm_update);
          if (got.duty_voltage !== want.duty_voltage)
            report_mismatch("duty_voltage", got.duty_voltage, want.duty_voltage);
          if (got.duty_current !== want.duty_current)
            report_mismatch("duty_current", got.duty_current, want.duty_current);
          if (got.report_valid !== want.report_valid)
            report_mismatch("report_valid", got.report_valid, want.report_valid);
          if (got.real_power !== want.real_power)
            report_mismatch("real_power", got.real_power, want.real_power);
          if (got.reactive_power !== want.reactive_power)
            report_mismatch("reactive_power", got.reactive_power, want.reactive_power);
          if (got.apparent_power !== want.apparent_power)
            report_mismatch("apparent_power", got.apparent_power, want.apparent_power);
          if (got.power_angle !== want.power_angle)
            report_mismatch("power_angle", got.power_angle, want.power_angle);
          if (got.current_phase_out !== want.current_phase_out)
            report_mismatch("current_phase_out", got.current_phase_out,
                            want.current_phase_out);
          if (got.current_amplitude_out !== want.current_amplitude_out)
            report_mismatch("current_amplitude_out", got.current_amplitude_out,
                            want.current_amplitude_out);
          if (got.voltage_amplitude !== want.voltage_amplitude)
            report_mismatch("voltage_amplitude", got.voltage_amplitude,
                            want.voltage_amplitude);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w = '{in_ch.time_us, in_ch.knob_amplitude, in_ch.knob_phase,
              in_ch.knob_real, in_ch.knob_reactive};
        expected_words.push_back(predict_word(w));
      end
    end
    words_pending = expected_words.size();
  end
endmodule

@@ tb/phasor_sine_pwm_with_power_triangle_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phasor_sine_pwm_with_power_triangle_tb
// Drives timestamped knob words through the sine duty / power triangle block
// across several register settings, with random gaps and output stalls. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module phasor_sine_pwm_with_power_triangle_tb;
  import psp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;  // idle cycles before giving up
  localparam int SETTLE_CYCLES  = 300;    // worst-case word latency, padded

  logic clk;
  logic rst_n;
  int   mismatches;
  int   words_pending;
  int   idle_cycles;

  // settings the stimulus shapes its timestamps around
  longint pwm_gap_us;
  longint rpt_gap_us;
  logic [31:0] now_us;
  bit   no_gaps;      // stretch with back-to-back words
  bit   out_busy;     // stretch where the sink stalls a lot

  psp_in_if  in_ch();
  psp_out_if out_ch();
  psp_cfg_if cfg_ch();

  phasor_sine_pwm_with_power_triangle i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  phasor_sine_pwm_with_power_triangle_chk i_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 60);
  endfunction

  // sink side: random stalls at the falling edge
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        out_ch.ready = out_busy ? ($urandom_range(0, 3) == 0) : 1'b1;
        if (!out_busy && $urandom_range(0, 7) == 0) begin
          out_ch.ready = 1'b0;
          hold = gap_len();
        end
      end
    end
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // wait for the block to drain before touching registers
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [10:0] fs, input logic [9:0] f,
                               input logic [19:0] pwm, input logic [23:0] rpt);
    drain();
    reg_write(REG_FULL_SCALE, 32'(fs));
    reg_write(REG_FREQ, 32'(f));
    reg_write(REG_PWM_IVL, 32'(pwm));
    reg_write(REG_RPT_IVL, 32'(rpt));
    pwm_gap_us = longint'(pwm);
    rpt_gap_us = longint'(rpt);
  endtask

  task automatic send_word(input logic [31:0] t, input logic [11:0] ka,
                           input logic [11:0] kp, input logic [11:0] kr,
                           input logic [11:0] kq);
    int g;
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.time_us        = t;
    in_ch.knob_amplitude = ka;
    in_ch.knob_phase     = kp;
    in_ch.knob_real      = kr;
    in_ch.knob_reactive  = kq;
    do @(posedge clk); while (!in_ch.ready);
    g = no_gaps ? 0 : gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // next timestamp: mostly around the duty interval, some report-sized
  // jumps, a few arbitrary values (covers wrap and every time bit)
  task automatic send_random();
    longint step;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13)      step = $urandom_range(0, 32'(2 * pwm_gap_us + 2));
    else if (sel < 18) step = rpt_gap_us + $urandom_range(0, 32'(rpt_gap_us / 4 + 2)) - 1;
    else               step = $urandom;
    now_us = now_us + 32'(step);
    send_word(now_us, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
  endtask

  task automatic random_run(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        no_gaps  = ($urandom_range(0, 3) == 0);
        out_busy = ($urandom_range(0, 3) == 0);
      end
      send_random();
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.time_us        = '0;
    in_ch.knob_amplitude = '0;
    in_ch.knob_phase     = '0;
    in_ch.knob_real      = '0;
    in_ch.knob_reactive  = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_FULL_SCALE;
    cfg_ch.data          = '0;
    no_gaps              = 1'b0;
    out_busy             = 1'b0;
    pwm_gap_us           = 500;
    rpt_gap_us           = 500000;
    now_us               = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, every interval decision, knob extremes
    send_word(32'd0, 12'd4095, 12'd0, 12'd0, 12'd0);            // no update
    send_word(32'd500, 12'd4095, 12'd4095, 12'd4095, 12'd4095); // at interval
    send_word(32'd501, 12'd4095, 12'd4095, 12'd4095, 12'd4095); // duty only
    send_word(32'd500001, 12'd0, 12'd2048, 12'd4095, 12'd0);    // report, amp 0
    send_word(32'd1000002, 12'd4095, 12'd1024, 12'd0, 12'd0);   // P=Q=0
    send_word(32'd1500003, 12'd1, 12'd3071, 12'd0, 12'd4095);   // pure Q
    send_word(32'd2000004, 12'd4095, 12'd0, 12'd4095, 12'd4095);
    send_word(32'd2000600, 12'd2048, 12'd1, 12'd1, 12'd1);
    send_word(32'hFFFF_FFF0, 12'd4095, 12'd4094, 12'd3000, 12'd1000); // far jump
    send_word(32'h0000_0300, 12'd4095, 12'd512, 12'd2000, 12'd2000);  // wrap
    send_word(32'h0000_0301, 12'd0, 12'd0, 12'd4095, 12'd4095);

    // every directed word updates both: max full scale, frequency 1000
    apply_setting(11'd2047, 10'd1000, 20'd0, 24'd0);
    send_word(32'd1, 12'd4095, 12'd0, 12'd4095, 12'd4095);
    send_word(32'd250, 12'd4095, 12'd1024, 12'd0, 12'd0);
    send_word(32'd500, 12'd4095, 12'd2048, 12'd4095, 12'd0);
    send_word(32'd750, 12'd4095, 12'd3072, 12'd1, 12'd4095);
    send_word(32'd1000, 12'd0, 12'd4095, 12'd100, 12'd100);
    now_us = 32'd1000;
    random_run(300);

    // back to reset values, then hold off once until all words are back
    apply_setting(11'd2000, 10'd60, 20'd500, 24'd500000);
    random_run(150);
    drain();
    random_run(150);

    // zero full scale, frequency 1, intervals 1000000 us and 10000000 us
    apply_setting(11'd0, 10'd1, 20'd1000000, 24'd10000000);
    send_word(now_us + 32'd10000001, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    now_us = now_us + 32'd10000001;
    random_run(200);

    apply_setting(11'd1023, 10'd999, 20'd1000, 24'd0);
    random_run(200);

    for (int k = 0; k < 4; k++) begin
      apply_setting(11'($urandom_range(0, 2047)), 10'($urandom_range(1, 1000)),
                    20'($urandom_range(0, 2000)), 24'($urandom_range(0, 20000)));
      random_run(200);
    end

    // let everything come back, then settle
    drain();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/psp_pkg.sv
design/psp_if.sv
design/psp_ctrl.sv
design/psp_dp.sv
design/phasor_sine_pwm_with_power_triangle.sv
design/psp_checker.sv
tb/phasor_sine_pwm_with_power_triangle_chk.sv
tb/phasor_sine_pwm_with_power_triangle_tb.sv
